/* hdl/bptc_pkg.sv */
// shared constants, types and helpers of the barometric compensation block
package bptc_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned TRIM_W  = 48;
    localparam int unsigned RAW_W   = 20;
    localparam int unsigned CNT_W   = 7;

    localparam logic [1:0] CFG_TEMP_TRIM    = 2'd0;
    localparam logic [1:0] CFG_PRESS_TRIM_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_TRIM_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_TRIM_C = 2'd3;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [63:0] T_OFFSET    = 64'd128000;
    localparam logic [63:0] P_BASE      = 64'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [63:0] P_BIAS      = 64'd1 << 47;
    localparam logic [31:0] ROUND_HALF  = 32'd128;

    // handshake between the sequencer and a serial arithmetic unit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_unit_rsp;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [63:0] v);
        sx32 = {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] sra(input logic [63:0] v, input logic [5:0] s);
        sra = 64'($signed(v) >>> s);
    endfunction

endpackage

/* hdl/baro_temp_pressure_compensation_unit.sv */
// top level: trim registers, compensation sequencer and result register
//
// Input channel: i_valid with i_op and i_raw_reading; the block stalls it
// with o_stall. One item is worked on at a time: o_stall is low only while
// the sequencer is idle. Output channel: o_valid with o_kind, o_temperature,
// o_pressure and o_div_guard; the receiver stalls it with i_stall.
// Every item gives exactly one result. The arithmetic runs through one
// bit-serial multiplier and one bit-serial divider. Trims are written
// through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Reset clears trims, the stored fine temperature and all control state.
// While the receiver stalls, the result register holds its item and a
// finished item waits in the sequencer until the register frees up.
module baro_temp_pressure_compensation_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [bptc_pkg::TRIM_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [bptc_pkg::RAW_W-1:0]   i_raw_reading,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic signed [31:0]           o_temperature,
    output logic [31:0]                  o_pressure,
    output logic                         o_div_guard
);
    import bptc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [TRIM_W-1:0] r_tt, r_pa, r_pb, r_pc;
    logic [31:0] r_ft, n_ft;
    logic        r_op;
    logic [RAW_W-1:0] r_raw;
    logic [63:0] r_x, n_x, r_y, n_y, r_t, n_t, r_p, n_p, r_a, n_a;
    logic        r_ovalid, n_ovalid;
    logic        r_kind, n_kind, r_guard, n_guard;
    logic [31:0] r_temp, n_temp, r_press, n_press;

    t_unit_req mul_req, div_req;
    t_unit_rsp mul_rsp, div_rsp;

    bptc_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    bptc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, raw64;
    assign t1 = {48'd0, r_tt[15:0]};
    assign t2 = sx16(r_tt[31:16]);
    assign t3 = sx16(r_tt[47:32]);
    assign p1 = {48'd0, r_pa[15:0]};
    assign p2 = sx16(r_pa[31:16]);
    assign p3 = sx16(r_pa[47:32]);
    assign p4 = sx16(r_pb[15:0]);
    assign p5 = sx16(r_pb[31:16]);
    assign p6 = sx16(r_pb[47:32]);
    assign p7 = sx16(r_pc[15:0]);
    assign p8 = sx16(r_pc[31:16]);
    assign p9 = sx16(r_pc[47:32]);
    assign raw64 = {{(WORD_W-RAW_W){1'b0}}, r_raw};

    logic out_free;
    assign out_free = !r_ovalid || !i_stall;

    // trim registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tt <= '0;
            r_pa <= '0;
            r_pb <= '0;
            r_pc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP_TRIM:    r_tt <= i_cfg_data;
                CFG_PRESS_TRIM_A: r_pa <= i_cfg_data;
                CFG_PRESS_TRIM_B: r_pb <= i_cfg_data;
                CFG_PRESS_TRIM_C: r_pc <= i_cfg_data;
                default:          r_tt <= r_tt;
            endcase
        end
    end

    // sequencer: each step consumes the last product or quotient and issues the next operation or finishes the item
    always_comb begin
        logic [63:0] m, xv, pv, ftn, t5, bv;
        logic        last;
        m        = mul_rsp.res;
        xv       = '0;
        pv       = '0;
        ftn      = '0;
        t5       = '0;
        bv       = '0;
        last     = 1'b0;
        n_state  = r_state;
        n_step   = r_step;
        n_ft     = r_ft;
        n_x      = r_x;
        n_y      = r_y;
        n_t      = r_t;
        n_p      = r_p;
        n_a      = r_a;
        n_ovalid = r_ovalid && i_stall;
        n_kind   = r_kind;
        n_guard  = r_guard;
        n_temp   = r_temp;
        n_press  = r_press;
        mul_req  = '0;
        div_req  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_STEP;
                    n_step  = '0;
                end
            end
            ST_WAIT: begin
                if (mul_rsp.done || div_rsp.done) begin
                    n_state = ST_STEP;
                    n_step  = r_step + 1'b1;
                end
            end
            ST_STEP: begin
                n_state = ST_WAIT;
                if (r_op == OP_TEMP) begin
                    unique case (r_step)
                        4'd0: begin
                            mul_req = '{1'b1, sx32((raw64 >> 3) - (t1 << 1)), t2};
                        end
                        4'd1: begin
                            n_a     = sra(sx32(m), 6'd11);
                            mul_req = '{1'b1, sx32((raw64 >> 4) - t1),
                                              sx32((raw64 >> 4) - t1)};
                        end
                        4'd2: begin
                            mul_req = '{1'b1, sra(sx32(m), 6'd12), t3};
                        end
                        default: begin
                            last = 1'b1;
                            bv   = sra(sx32(m), 6'd14);
                            ftn  = {32'd0, r_a[31:0] + bv[31:0]};
                            t5   = sx32({ftn[61:0], 2'b00} + ftn + {32'd0, ROUND_HALF});
                            if (out_free) begin
                                n_ft     = ftn[31:0];
                                n_ovalid = 1'b1;
                                n_kind   = OP_TEMP;
                                n_guard  = 1'b0;
                                n_press  = '0;
                                n_temp   = t5[39:8];
                            end
                        end
                    endcase
                end else begin
                    unique case (r_step)
                        4'd0: begin
                            xv      = sx32({32'd0, r_ft}) - T_OFFSET;
                            n_x     = xv;
                            mul_req = '{1'b1, xv, xv};
                        end
                        4'd1: begin
                            n_t     = m;
                            mul_req = '{1'b1, m, p6};
                        end
                        4'd2: begin
                            n_y     = m;
                            mul_req = '{1'b1, r_x, p5};
                        end
                        4'd3: begin
                            n_y     = r_y + (m << 17) + (p4 << 35);
                            mul_req = '{1'b1, r_t, p3};
                        end
                        4'd4: begin
                            n_a     = sra(m, 6'd8);
                            mul_req = '{1'b1, r_x, p2};
                        end
                        4'd5: begin
                            mul_req = '{1'b1, P_BIAS + r_a + (m << 12), p1};
                        end
                        4'd6: begin
                            xv  = sra(m, 6'd33);
                            n_x = xv;
                            pv  = P_BASE - raw64;
                            if (xv == '0) begin
                                last = 1'b1;
                                if (out_free) begin
                                    n_ovalid = 1'b1;
                                    n_kind   = OP_PRESS;
                                    n_guard  = 1'b1;
                                    n_press  = '0;
                                    n_temp   = '0;
                                end
                            end else begin
                                mul_req = '{1'b1, (pv << 31) - r_y, P_SCALE};
                            end
                        end
                        4'd7: begin
                            div_req = '{1'b1, m, r_x};
                        end
                        4'd8: begin
                            n_p     = div_rsp.res;
                            n_t     = sra(div_rsp.res, 6'd13);
                            mul_req = '{1'b1, p9, sra(div_rsp.res, 6'd13)};
                        end
                        4'd9: begin
                            mul_req = '{1'b1, m, r_t};
                        end
                        4'd10: begin
                            n_a     = sra(m, 6'd25);
                            mul_req = '{1'b1, p8, r_p};
                        end
                        default: begin
                            last = 1'b1;
                            pv   = sra(r_p + r_a + sra(m, 6'd19), 6'd8) + (p7 << 4);
                            if (out_free) begin
                                n_ovalid = 1'b1;
                                n_kind   = OP_PRESS;
                                n_guard  = 1'b0;
                                n_press  = pv[31:0];
                                n_temp   = '0;
                            end
                        end
                    endcase
                end
                // a finished item leaves only when the result register is free
                if (last) begin
                    n_state = out_free ? ST_IDLE : ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ft     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ft     <= n_ft;
            r_ovalid <= n_ovalid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_op  <= i_op;
            r_raw <= i_raw_reading;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_t     <= n_t;
        r_p     <= n_p;
        r_a     <= n_a;
        r_kind  <= n_kind;
        r_guard <= n_guard;
        r_temp  <= n_temp;
        r_press <= n_press;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_kind        = r_kind;
    assign o_temperature = $signed(r_temp);
    assign o_pressure    = r_press;
    assign o_div_guard   = r_guard;

endmodule

/* hdl/bptc_mul.sv */
// bit-serial shift-add multiplier, low 64 bits of the product
module bptc_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bptc_pkg::t_unit_req i_req,
    output bptc_pkg::t_unit_rsp o_rsp
);
    import bptc_pkg::*;

    logic [63:0]      r_ma, r_mb, r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= i_req.a;
            r_mb  <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_mb[0]) begin
                r_acc <= r_acc + r_ma;
            end
            r_ma <= {r_ma[62:0], 1'b0};
            r_mb <= {1'b0, r_mb[63:1]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule

/* hdl/bptc_div.sv */
// bit-serial restoring signed divider, truncates toward zero
module bptc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bptc_pkg::t_unit_req i_req,
    output bptc_pkg::t_unit_rsp o_rsp
);
    import bptc_pkg::*;

    logic [63:0]      r_n, r_d, r_rem, r_q;
    logic             r_neg, r_busy, r_fix, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [64:0]      rem_sh, diff;

    assign rem_sh = {r_rem, r_n[63]};
    assign diff   = rem_sh - {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle, sign applied at the end
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_n   <= i_req.a[63] ? (64'd0 - i_req.a) : i_req.a;
            r_d   <= i_req.b[63] ? (64'd0 - i_req.b) : i_req.b;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[64]) begin
                r_rem <= diff[63:0];
                r_n   <= {r_n[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[63:0];
                r_n   <= {r_n[62:0], 1'b0};
            end
        end else if (r_fix) begin
            r_q <= r_neg ? (64'd0 - r_n) : r_n;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;

endmodule

/* hdl/bptc_checker.sv */
// port-level checks of the compensation block, bound to the top level
module bptc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_kind,
    input logic [31:0] o_temperature,
    input logic [31:0] o_pressure,
    input logic        o_div_guard
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pressure) && $stable(o_temperature))
        else $error("stalled result changed");

    // temperature results carry no pressure and no guard
    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_pressure == 32'd0 && !o_div_guard)
        else $error("temperature item with pressure fields");

    // the guard only comes with a zero pressure
    a_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_guard |-> o_kind && o_pressure == 32'd0 && o_temperature == 32'd0)
        else $error("guard with nonzero result");

    // one item at a time: an accepted item closes the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after an item");

endmodule

bind baro_temp_pressure_compensation_unit bptc_checker u_bptc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind),
    .o_temperature(o_temperature), .o_pressure(o_pressure), .o_div_guard(o_div_guard)
);
